// ===== rtl/vsr_pkg.sv =====
// Shared types and codes for the video scroll register file.
package vsr_pkg;

	// Request codes.
	localparam logic [3:0] REQ_REG_WRITE = 4'd0;
	localparam logic [3:0] REQ_REG_READ  = 4'd1;
	localparam logic [3:0] REQ_STEP_X    = 4'd2;
	localparam logic [3:0] REQ_STEP_Y    = 4'd3;
	localparam logic [3:0] REQ_COPY_HORZ = 4'd4;
	localparam logic [3:0] REQ_COPY_VERT = 4'd5;
	localparam logic [3:0] REQ_SET_VBL   = 4'd6;
	localparam logic [3:0] REQ_SET_HIT   = 4'd7;
	localparam logic [3:0] REQ_SET_OVF   = 4'd8;
	localparam logic [3:0] REQ_CLR_FLAGS = 4'd9;

	// Register indexes.
	localparam logic [2:0] REG_CTRL     = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_SPR_ADDR = 3'd3;
	localparam logic [2:0] REG_SPR_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	// Sprite store geometry.
	localparam int SPRITE_STORE_BYTES = 256;
	localparam int SPR_AW = $clog2(SPRITE_STORE_BYTES);

	// Palette region threshold for unbuffered data reads.
	localparam logic [15:0] PALETTE_BASE = 16'h3F00;
	localparam logic [4:0]  ROW_LAST_VISIBLE = 5'd29;
	localparam logic [4:0]  ROW_LAST = 5'd31;

	typedef struct packed {
		logic [3:0] req_type;
		logic [2:0] reg_select;
		logic [7:0] write_data;
		logic [7:0] vram_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        mem_write_enable;
		logic [15:0] mem_write_address;
		logic [7:0]  mem_write_byte;
		logic [15:0] vram_address;
		logic [7:0]  control_value;
		logic [7:0]  mask_value;
		logic [2:0]  fine_scroll_x;
		logic [7:0]  status_value;
	} rsp_t;

	// Sprite store port controls.
	typedef struct packed {
		logic              wr_en;
		logic [SPR_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic [SPR_AW-1:0] rd_addr;
	} spr_ctl_t;

endpackage

// ===== rtl/vsr_sprite_mem.sv =====
// Sprite store: 256-byte memory with per-entry valid bits and registered read.
module vsr_sprite_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  vsr_pkg::spr_ctl_t ctl,
	output logic [7:0]        rd_byte
);

	logic [7:0]                           mem [vsr_pkg::SPRITE_STORE_BYTES];
	logic [vsr_pkg::SPRITE_STORE_BYTES-1:0] valid_q;
	logic [7:0]                           rd_data_q;
	logic                                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		rd_data_q <= mem[ctl.rd_addr];
	end

	// Entries never written read as zero, matching the cleared store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[ctl.rd_addr];
		end
	end

	assign rd_byte = rd_valid_q ? rd_data_q : 8'h00;

endmodule

// ===== rtl/vsr_regs.sv =====
// Architectural registers and the single-pass update for one request.
module vsr_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  vsr_pkg::req_t     req,
	input  logic [7:0]        spr_rd_byte,
	output vsr_pkg::rsp_t     rsp,
	output vsr_pkg::spr_ctl_t spr_ctl
);

	logic [7:0]                  control_q, control_d;
	logic [7:0]                  mask_q, mask_d;
	logic [2:0]                  status_q, status_d;
	logic [vsr_pkg::SPR_AW-1:0]  spr_addr_q, spr_addr_d;
	logic [15:0]                 cur_addr_q, cur_addr_d;
	logic [14:0]                 tmp_addr_q, tmp_addr_d;
	logic [2:0]                  fine_x_q, fine_x_d;
	logic                        toggle_q, toggle_d;
	logic [7:0]                  rbuf_q, rbuf_d;

	always_comb begin
		logic [15:0] incr;
		logic [7:0]  d;
		logic [4:0]  row;

		control_d  = control_q;
		mask_d     = mask_q;
		status_d   = status_q;
		spr_addr_d = spr_addr_q;
		cur_addr_d = cur_addr_q;
		tmp_addr_d = tmp_addr_q;
		fine_x_d   = fine_x_q;
		toggle_d   = toggle_q;
		rbuf_d     = rbuf_q;
		incr       = control_q[2] ? 16'd32 : 16'd1;
		d          = req.write_data;
		row        = cur_addr_q[9:5];

		rsp = '0;
		spr_ctl = '0;

		unique case (req.req_type)
			vsr_pkg::REQ_REG_WRITE: begin
				unique case (req.reg_select)
					vsr_pkg::REG_CTRL: begin
						control_d = d;
						tmp_addr_d[11:10] = d[1:0];
					end
					vsr_pkg::REG_MASK: mask_d = d;
					vsr_pkg::REG_SPR_ADDR: spr_addr_d = d[vsr_pkg::SPR_AW-1:0];
					vsr_pkg::REG_SPR_DATA: begin
						spr_ctl.wr_en   = 1'b1;
						spr_ctl.wr_addr = spr_addr_q;
						spr_ctl.wr_data = d;
						spr_addr_d      = spr_addr_q + vsr_pkg::SPR_AW'(1);
					end
					vsr_pkg::REG_SCROLL: begin
						if (toggle_q) begin
							tmp_addr_d[14:12] = d[2:0];
							tmp_addr_d[9:5]   = d[7:3];
							toggle_d          = 1'b0;
						end else begin
							tmp_addr_d[4:0] = d[7:3];
							fine_x_d        = d[2:0];
							toggle_d        = 1'b1;
						end
					end
					vsr_pkg::REG_ADDR: begin
						if (toggle_q) begin
							tmp_addr_d[7:0] = d;
							cur_addr_d      = {1'b0, tmp_addr_q[14:8], d};
							toggle_d        = 1'b0;
						end else begin
							tmp_addr_d[14]   = 1'b0;
							tmp_addr_d[13:8] = d[5:0];
							toggle_d         = 1'b1;
						end
					end
					vsr_pkg::REG_DATA: begin
						rsp.mem_write_enable  = 1'b1;
						rsp.mem_write_address = cur_addr_q;
						rsp.mem_write_byte    = d;
						cur_addr_d            = cur_addr_q + incr;
					end
					default: ;
				endcase
			end
			vsr_pkg::REQ_REG_READ: begin
				unique case (req.reg_select)
					vsr_pkg::REG_STATUS: begin
						rsp.read_data = {status_q, 5'b0};
						toggle_d      = 1'b0;
						status_d[2]   = 1'b0;
					end
					vsr_pkg::REG_SPR_DATA: rsp.read_data = spr_rd_byte;
					vsr_pkg::REG_DATA: begin
						// Palette reads bypass the buffer but still refill it.
						rsp.read_data = (cur_addr_q >= vsr_pkg::PALETTE_BASE) ?
							req.vram_byte : rbuf_q;
						rbuf_d        = req.vram_byte;
						cur_addr_d    = cur_addr_q + incr;
					end
					default: ;
				endcase
			end
			vsr_pkg::REQ_STEP_X: begin
				if (cur_addr_q[4:0] == 5'h1F) begin
					cur_addr_d[4:0] = 5'h00;
					cur_addr_d[10]  = ~cur_addr_q[10];
				end else begin
					cur_addr_d = cur_addr_q + 16'd1;
				end
			end
			vsr_pkg::REQ_STEP_Y: begin
				if (cur_addr_q[14:12] != 3'h7) begin
					cur_addr_d[14:12] = cur_addr_q[14:12] + 3'd1;
				end else begin
					cur_addr_d[14:12] = 3'h0;
					if (row == vsr_pkg::ROW_LAST_VISIBLE) begin
						cur_addr_d[9:5] = 5'd0;
						cur_addr_d[11]  = ~cur_addr_q[11];
					end else if (row == vsr_pkg::ROW_LAST) begin
						cur_addr_d[9:5] = 5'd0;
					end else begin
						cur_addr_d[9:5] = row + 5'd1;
					end
				end
			end
			vsr_pkg::REQ_COPY_HORZ: begin
				cur_addr_d[10]  = tmp_addr_q[10];
				cur_addr_d[4:0] = tmp_addr_q[4:0];
			end
			vsr_pkg::REQ_COPY_VERT: begin
				cur_addr_d[14:11] = tmp_addr_q[14:11];
				cur_addr_d[9:5]   = tmp_addr_q[9:5];
			end
			vsr_pkg::REQ_SET_VBL:   status_d[2] = 1'b1;
			vsr_pkg::REQ_SET_HIT:   status_d[1] = 1'b1;
			vsr_pkg::REQ_SET_OVF:   status_d[0] = 1'b1;
			vsr_pkg::REQ_CLR_FLAGS: status_d = 3'b000;
			default: ;
		endcase

		rsp.vram_address  = cur_addr_d;
		rsp.control_value = control_d;
		rsp.mask_value    = mask_d;
		rsp.fine_scroll_x = fine_x_d;
		rsp.status_value  = {status_d, 5'b0};

		// The sprite read port looks ahead to the address the next request will see.
		spr_ctl.rd_addr = commit ? spr_addr_d : spr_addr_q;
		spr_ctl.wr_en   = spr_ctl.wr_en & commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= '0;
			mask_q     <= '0;
			status_q   <= '0;
			spr_addr_q <= '0;
			cur_addr_q <= '0;
			tmp_addr_q <= '0;
			fine_x_q   <= '0;
			toggle_q   <= 1'b0;
			rbuf_q     <= '0;
		end else if (commit) begin
			control_q  <= control_d;
			mask_q     <= mask_d;
			status_q   <= status_d;
			spr_addr_q <= spr_addr_d;
			cur_addr_q <= cur_addr_d;
			tmp_addr_q <= tmp_addr_d;
			fine_x_q   <= fine_x_d;
			toggle_q   <= toggle_d;
			rbuf_q     <= rbuf_d;
		end
	end

endmodule

// ===== rtl/video_scroll_register_file_top.sv =====
// Top level of the video scroll register file: input register, update logic, result register.
// One request (bus access or render event) is taken per clock unless the output stalls; each
// gives exactly one result. A transfer on req lands in an input register; once it can advance,
// the whole update is done in one pass and the result is loaded into the output register, so
// the block sustains one request per cycle while rsp_ready stays high. req_ready follows
// rsp_ready combinationally when both registers are full. The 256-byte sprite store sits in a
// memory with registered read, read one address ahead; a valid bit per byte makes
// never-written bytes read as zero, so no clearing pass is needed.
module video_scroll_register_file_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  vsr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output vsr_pkg::rsp_t rsp
);

	logic              valid_s1;
	vsr_pkg::req_t     req_s1;
	logic              valid_s2;
	vsr_pkg::rsp_t     rsp_s2;
	logic              advance;
	vsr_pkg::rsp_t     rsp_comb;
	vsr_pkg::spr_ctl_t spr_ctl;
	logic [7:0]        spr_rd_byte;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_comb;
		end
	end

	vsr_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (advance),
		.req        (req_s1),
		.spr_rd_byte(spr_rd_byte),
		.rsp        (rsp_comb),
		.spr_ctl    (spr_ctl)
	);

	vsr_sprite_mem u_sprite_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (spr_ctl),
		.rd_byte(spr_rd_byte)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// A stalled request must not be dropped from the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register lost a stalled request");

	// A memory write transfer never returns read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.mem_write_enable) |-> (rsp.read_data == 8'h00))
		else $error("memory write result carries read data");

	// Sprite store writes happen only when a request is committed.
	assert property (@(posedge clk) disable iff (!arst_n)
		spr_ctl.wr_en |-> advance)
		else $error("sprite store written without a committed request");

endmodule
